>>> sv/spr_pkg.sv
package spr_pkg;

    // Base ticks per ramp tick
    localparam int RAMP_DIVIDE = 16;
    localparam int PRESCALE_W  = (RAMP_DIVIDE > 1) ? $clog2(RAMP_DIVIDE) : 1;
    localparam logic [PRESCALE_W-1:0] PRESCALE_LAST = PRESCALE_W'(RAMP_DIVIDE - 1);

    localparam logic [7:0] PERIOD_SLOW   = 8'd255;
    localparam logic [7:0] ACC_SLOW      = 8'd255;
    localparam logic [6:0] PCT_MAX       = 7'd100;
    localparam logic [7:0] RAMP_PER_RST  = 8'd4;
    localparam logic [6:0] ACCEL_RST     = 7'd99;

    // Reciprocal constants, all scaled by 2^19 or 2^20
    // pct*251/100 -> (pct*1315993) >> 19
    localparam logic [27:0] SPEED_RECIP = 28'd1315993;
    // pct*254/100 -> (pct*1331722) >> 19
    localparam logic [27:0] ACCEL_RECIP = 28'd1331722;
    // x*100/251   -> (x*417760) >> 20
    localparam logic [26:0] RB_RECIP    = 27'd417760;

    typedef enum logic [2:0] {
        CMD_TICK      = 3'd0,
        CMD_TARGET    = 3'd1,
        CMD_IMMEDIATE = 3'd2,
        CMD_DIRECTION = 3'd3,
        CMD_HALT      = 3'd4,
        CMD_START     = 3'd5
    } t_cmd;

    // Registered input beat, with the speed already mapped to a half-period
    typedef struct packed {
        logic [2:0] command;
        logic [7:0] speed_period;
        logic       direction;
    } t_item;

    // Speed percent to half-period: 255 - min(pct,100)*251/100
    function automatic logic [7:0] speed_to_period(input logic [6:0] pct);
        logic [6:0]  p;
        logic [27:0] prod;
        p    = (pct > PCT_MAX) ? PCT_MAX : pct;
        prod = 28'(p) * SPEED_RECIP;
        return PERIOD_SLOW - prod[26:19];
    endfunction

    // Accel percent to ramp period: 255 - min(pct,100)*254/100
    function automatic logic [7:0] accel_to_ramp(input logic [6:0] pct);
        logic [6:0]  p;
        logic [27:0] prod;
        p    = (pct > PCT_MAX) ? PCT_MAX : pct;
        prod = 28'(p) * ACCEL_RECIP;
        return ACC_SLOW - prod[26:19];
    endfunction

    // Half-period to speed percent: (255-p)*100/251, capped at 100
    function automatic logic [6:0] period_to_percent(input logic [7:0] per);
        logic [7:0]  x;
        logic [26:0] prod;
        x    = PERIOD_SLOW - per;
        prod = 27'(x) * RB_RECIP;
        return (prod[26:20] > PCT_MAX) ? PCT_MAX : prod[26:20];
    endfunction

endpackage

>>> sv/spr_cmd_if.sv
interface spr_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] command;
    logic [6:0] speed_percent;
    logic       direction;

    modport source (output valid, command, speed_percent, direction, input ready);
    modport sink   (input valid, command, speed_percent, direction, output ready);
endinterface

>>> sv/spr_res_if.sv
interface spr_res_if;
    logic       valid;
    logic       ready;
    logic       step_level;
    logic       dir_level;
    logic [7:0] half_period;
    logic [6:0] speed_readback;
    logic       at_target;
    logic       running;

    modport source (output valid, step_level, dir_level, half_period, speed_readback,
                    at_target, running, input ready);
    modport sink   (input valid, step_level, dir_level, half_period, speed_readback,
                    at_target, running, output ready);
endinterface

>>> sv/spr_cfg_if.sv
interface spr_cfg_if;
    logic       valid;
    logic       ready;
    logic [6:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

>>> sv/stepper_pulse_ramp_generator_core.sv
// Stepper pulse generator with linear speed ramp.
// An accepted command beat passes the input register, then the state
// update into the result register.
// Throughput: one beat per cycle while the result slot is empty or being emptied.
// Reset (synchronous, active low): halted, lines low, counters zero,
// current and target half-period 255, accel percent 99 (ramp period 4).
module stepper_pulse_ramp_generator_core
    import spr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    spr_cmd_if.sink    i_cmd,
    spr_cfg_if.sink    i_cfg,
    spr_res_if.source  o_res
);

    logic  in_valid;
    t_item in_item;
    logic  take;

    spr_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (i_cmd),
        .o_valid (in_valid),
        .o_item  (in_item),
        .i_take  (take)
    );

    spr_exec u_exec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_valid),
        .i_item  (in_item),
        .o_take  (take),
        .i_cfg   (i_cfg),
        .o_res   (o_res)
    );

endmodule

>>> sv/spr_in_stage.sv
module spr_in_stage
    import spr_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    spr_cmd_if.sink       i_cmd,
    output logic          o_valid,
    output t_item         o_item,
    input  logic          i_take
);

    logic  r_valid;
    t_item r_item;
    logic  load;

    // Stage is free when empty or being drained this cycle
    assign i_cmd.ready = !r_valid || i_take;
    assign load        = i_cmd.valid && i_cmd.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    // Payload: speed is mapped to a half-period on capture
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item.command      <= i_cmd.command;
            r_item.speed_period <= speed_to_period(i_cmd.speed_percent);
            r_item.direction    <= i_cmd.direction;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

>>> sv/spr_exec.sv
module spr_exec
    import spr_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  t_item         i_item,
    output logic          o_take,
    spr_cfg_if.sink       i_cfg,
    spr_res_if.source     o_res
);

    // Motor state
    logic [7:0]            r_step_count,  n_step_count;
    logic [7:0]            r_ramp_count,  n_ramp_count;
    logic [PRESCALE_W-1:0] r_prescale,    n_prescale;
    logic [7:0]            r_cur_period,  n_cur_period;
    logic [7:0]            r_tgt_period,  n_tgt_period;
    logic                  r_step_line,   n_step_line;
    logic                  r_dir_line,    n_dir_line;
    logic                  r_run,         n_run;
    logic [7:0]            r_ramp_period;

    // Result register
    logic       r_out_valid;
    logic       r_out_step;
    logic       r_out_dir;
    logic [7:0] r_out_period;
    logic [6:0] r_out_rb;
    logic       r_out_at_tgt;
    logic       r_out_run;

    // Advance when the result slot is empty or being emptied
    assign o_take = i_valid && (!r_out_valid || o_res.ready);

    // Config: ramp period is mapped on write
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ramp_period <= RAMP_PER_RST;
        end else if (i_cfg.valid) begin
            r_ramp_period <= accel_to_ramp(i_cfg.data);
        end
    end

    // Next-state logic for one beat
    always_comb begin
        n_step_count = r_step_count;
        n_ramp_count = r_ramp_count;
        n_prescale   = r_prescale;
        n_cur_period = r_cur_period;
        n_tgt_period = r_tgt_period;
        n_step_line  = r_step_line;
        n_dir_line   = r_dir_line;
        n_run        = r_run;
        case (i_item.command)
            CMD_TICK: begin
                if (r_run) begin
                    // step half-period counter
                    if (r_step_count == r_cur_period) begin
                        n_step_line  = !r_step_line;
                        n_step_count = '0;
                    end else begin
                        n_step_count = r_step_count + 8'd1;
                    end
                    // prescaler, then ramp tick
                    if (r_prescale == PRESCALE_LAST) begin
                        n_prescale = '0;
                        if (r_ramp_count == r_ramp_period) begin
                            n_ramp_count = '0;
                            if (r_cur_period > r_tgt_period) begin
                                n_cur_period = r_cur_period - 8'd1;
                            end else if (r_cur_period < r_tgt_period) begin
                                n_cur_period = r_cur_period + 8'd1;
                            end
                        end else begin
                            n_ramp_count = r_ramp_count + 8'd1;
                        end
                    end else begin
                        n_prescale = r_prescale + PRESCALE_W'(1);
                    end
                end
            end
            CMD_TARGET: begin
                n_tgt_period = i_item.speed_period;
            end
            CMD_IMMEDIATE: begin
                n_tgt_period = i_item.speed_period;
                n_cur_period = i_item.speed_period;
            end
            CMD_DIRECTION: begin
                n_dir_line = i_item.direction;
            end
            CMD_HALT: begin
                n_run = 1'b0;
            end
            CMD_START: begin
                n_run        = 1'b1;
                n_step_line  = 1'b0;
                n_dir_line   = 1'b0;
                n_step_count = '0;
                n_ramp_count = '0;
                n_prescale   = '0;
                n_cur_period = PERIOD_SLOW;
            end
            default: begin
                // unused codes leave the state alone
            end
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_count <= '0;
            r_ramp_count <= '0;
            r_prescale   <= '0;
            r_cur_period <= PERIOD_SLOW;
            r_tgt_period <= PERIOD_SLOW;
            r_step_line  <= 1'b0;
            r_dir_line   <= 1'b0;
            r_run        <= 1'b0;
        end else if (o_take) begin
            r_step_count <= n_step_count;
            r_ramp_count <= n_ramp_count;
            r_prescale   <= n_prescale;
            r_cur_period <= n_cur_period;
            r_tgt_period <= n_tgt_period;
            r_step_line  <= n_step_line;
            r_dir_line   <= n_dir_line;
            r_run        <= n_run;
        end
    end

    // Result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_take) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload, taken after the update
    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_out_step   <= n_step_line;
            r_out_dir    <= n_dir_line;
            r_out_period <= n_cur_period;
            r_out_rb     <= period_to_percent(n_cur_period);
            r_out_at_tgt <= (n_cur_period == n_tgt_period);
            r_out_run    <= n_run;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.step_level     = r_out_step;
    assign o_res.dir_level      = r_out_dir;
    assign o_res.half_period    = r_out_period;
    assign o_res.speed_readback = r_out_rb;
    assign o_res.at_target      = r_out_at_tgt;
    assign o_res.running        = r_out_run;

endmodule
